/* rtl/core/hav_dist_pkg.sv */
// Shared types, fixed-point constants and elaboration-time helper functions
// for the haversine distance core. Depends on nothing else.
package hav_dist_pkg;

  // Width of the CORDIC x, y and z datapaths (signed).
  localparam int CW = 35;
  // Number of two-bit steps of the 64-bit square root.
  localparam int SQRT_STEPS = 32;
  // Length of the arctangent table.
  localparam int ATAN_LEN = 32;

  typedef logic signed [CW-1:0] cval_t;

  localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] TURN_UNITS = 64'd3600000000;

  // Multiplier from 1e-7 degree to half-angle radians, split into an upper and a lower word.
  localparam logic [29:0] TO_RAD_HI = 30'(PI_Q60 / TURN_UNITS);
  localparam logic [31:0] TO_RAD_LO = 32'(((PI_Q60 % TURN_UNITS) << 32) / TURN_UNITS);

  localparam logic [30:0] QUARTER_TURN = 31'd900000000;
  localparam logic [30:0] HALF_TURN    = 31'd1800000000;

  localparam logic [62:0] ONE_Q62   = 63'd1 << 62;
  localparam cval_t       UNIT_Q31  = cval_t'(64'd1 << 31);
  localparam logic [31:0] RADIUS_RESET = 32'd259457024;

  // Divides a power of two by the odd number 2k+1.
  function automatic logic [63:0] odd_div(input logic [63:0] p, input int k);
    logic [63:0] q;
    case (k)
      0:  q = p;
      1:  q = p / 64'd3;
      2:  q = p / 64'd5;
      3:  q = p / 64'd7;
      4:  q = p / 64'd9;
      5:  q = p / 64'd11;
      6:  q = p / 64'd13;
      7:  q = p / 64'd15;
      8:  q = p / 64'd17;
      9:  q = p / 64'd19;
      10: q = p / 64'd21;
      11: q = p / 64'd23;
      12: q = p / 64'd25;
      13: q = p / 64'd27;
      14: q = p / 64'd29;
      15: q = p / 64'd31;
      16: q = p / 64'd33;
      17: q = p / 64'd35;
      18: q = p / 64'd37;
      19: q = p / 64'd39;
      20: q = p / 64'd41;
      21: q = p / 64'd43;
      22: q = p / 64'd45;
      23: q = p / 64'd47;
      24: q = p / 64'd49;
      25: q = p / 64'd51;
      26: q = p / 64'd53;
      27: q = p / 64'd55;
      28: q = p / 64'd57;
      29: q = p / 64'd59;
      30: q = p / 64'd61;
      default: q = '0;
    endcase
    return q;
  endfunction

  // atan(2^-i) in Q32: Taylor series in Q62 with truncated terms, rounded.
  function automatic logic [63:0] atan_q32(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q60;
    end else begin
      for (int k = 0; k < 31; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = odd_div(64'd1 << e, k);
          if ((k % 2) == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
      end
    end
    return (acc + (64'd1 << 29)) >> 30;
  endfunction

  // Squared CORDIC gain in Q60 after the given number of steps.
  function automatic logic [63:0] cordic_gain_sq(input int steps);
    logic [63:0] g;
    g = 64'd1 << 60;
    for (int i = 0; i < ATAN_LEN; i++) begin
      if (i < steps) begin
        g = g + (g >> (2 * i));
      end
    end
    return g;
  endfunction

  // Floor square root, used on constants only.
  function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Brings a coordinate difference into the half-open range of one turn.
  function automatic logic signed [31:0] reduce_turn(input logic signed [32:0] d);
    logic signed [31:0] r;
    if (d >= 33'sd1800000000) begin
      r = 32'(d - 33'sd3600000000);
    end else if (d < -33'sd1800000000) begin
      r = 32'(d + 33'sd3600000000);
    end else begin
      r = 32'(d);
    end
    return r;
  endfunction

  // Magnitude of a value clamped to the unit range in Q31.
  function automatic logic [31:0] unit_mag(input cval_t v);
    logic [31:0] m;
    if (v > UNIT_Q31 || v < -UNIT_Q31) begin
      m = 32'h8000_0000;
    end else if (v < 0) begin
      m = 32'(-v);
    end else begin
      m = 32'(v);
    end
    return m;
  endfunction

endpackage

/* rtl/core/haversine_distance_core.sv */
// Haversine great-circle distance core: a fully pipelined datapath with
// CORDIC rotation, square root and CORDIC vectoring. Uses hav_dist_pkg.

// The core takes one pair of positions per cycle and returns the great-circle
// distance between them, in units of 2^-16 statute mile. The pipeline is made
// of the two CORDIC chains, one stage per step (24 steps by default), and the
// 32 stages of the 64-bit square root; every other step is a short register
// stage of its own. Items flow back to back: a new item is taken in every
// cycle unless the output register holds a result that the receiver is
// stalling, in which case the whole pipeline holds still and nothing is lost
// or repeated. The earth radius register is written through its own port,
// which is always ready, and must only be changed while no item is in
// flight.
module haversine_distance_core
  import hav_dist_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] start_lat_i,
  input  logic signed [31:0] start_lon_i,
  input  logic signed [30:0] end_lat_i,
  input  logic signed [31:0] end_lon_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [31:0] distance_o,
  // Earth radius register
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [31:0] earth_radius_i
);

  localparam int N = CORDIC_STEPS;

  // Total number of register stages, and the stages that the checks look at.
  localparam int LAT  = 14 + SQRT_STEPS + 2 * N;
  localparam int V_P6 = 10 + N;
  localparam int V_SQ = V_P6 + 1 + SQRT_STEPS;

  // The rotation start value is the inverse CORDIC gain in Q31.
  localparam logic [63:0] GAIN_SQ = cordic_gain_sq(N);
  localparam logic [63:0] GAIN    = isqrt_const(GAIN_SQ);
  localparam logic [63:0] K_START = (64'd1 << 61) / GAIN;
  localparam cval_t       K_C     = cval_t'(K_START);

  // Rotation lanes: half latitude difference, half longitude difference,
  // start latitude and end latitude.
  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_LAT1 = 2;
  localparam int LANE_LAT2 = 3;

  // ---------------------------------------------------------------------
  // Flow control. Every stage moves forward together; the whole pipeline holds
  // only while the output register holds a result that the receiver stalls.
  // ---------------------------------------------------------------------
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic [31:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= earth_radius_i;
    end
  end

  // ---------------------------------------------------------------------
  // Front end. Stage 1 forms the coordinate differences and the latitude
  // magnitudes.
  // ---------------------------------------------------------------------
  logic signed [31:0] s1_dlat_q;
  logic signed [32:0] s1_dlon_q;
  logic        [30:0] s1_latm_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dlat_q    <= {end_lat_i[30], end_lat_i} - {start_lat_i[30], start_lat_i};
      s1_dlon_q    <= {end_lon_i[31], end_lon_i} - {start_lon_i[31], start_lon_i};
      s1_latm_q[0] <= start_lat_i[30] ? (~start_lat_i + 31'd1) : start_lat_i;
      s1_latm_q[1] <= end_lat_i[30] ? (~end_lat_i + 31'd1) : end_lat_i;
    end
  end

  // Stage 2 wraps the differences into one turn. A latitude beyond a
  // quarter turn is folded back, and its cosine changes sign.
  logic signed [31:0] s2_dlat_q;
  logic signed [31:0] s2_dlon_q;
  logic        [30:0] s2_arg_q [2];
  logic        [1:0]  s2_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dlat_q <= reduce_turn({s1_dlat_q[31], s1_dlat_q});
      s2_dlon_q <= reduce_turn(s1_dlon_q);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_fold
    logic [30:0] folded;

    assign folded = (s1_latm_q[l] > QUARTER_TURN) ? (HALF_TURN - s1_latm_q[l])
                                                  : s1_latm_q[l];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s2_arg_q[l] <= {folded[29:0], 1'b0};
        s2_neg_q[l] <= s1_latm_q[l] > QUARTER_TURN;
      end
    end
  end

  // Stage 3 takes the magnitudes of the wrapped differences; sine of a
  // negative half angle only changes sign, which squaring removes.
  logic [30:0] s3_m_q [4];
  logic [1:0]  s3_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_m_q[LANE_DLAT] <= s2_dlat_q[31] ? 31'(-s2_dlat_q) : s2_dlat_q[30:0];
      s3_m_q[LANE_DLON] <= s2_dlon_q[31] ? 31'(-s2_dlon_q) : s2_dlon_q[30:0];
      s3_m_q[LANE_LAT1] <= s2_arg_q[0];
      s3_m_q[LANE_LAT2] <= s2_arg_q[1];
      s3_neg_q          <= s2_neg_q;
    end
  end

  // Stages 4 and 5 scale to radians in Q32 with two partial products,
  // then round.
  logic [60:0] s4_ph_q [4];
  logic [62:0] s4_pl_q [4];
  logic [1:0]  s4_neg_q;

  cval_t       rot_x_q [1:N][4];
  cval_t       rot_y_q [1:N][4];
  cval_t       rot_z_q [0:N][4];
  logic [1:0]  rot_neg_q [0:N];

  for (genvar l = 0; l < 4; l++) begin : g_rad
    logic [60:0] rad_sum;

    assign rad_sum = s4_ph_q[l] + 61'(s4_pl_q[l] >> 32) + (61'd1 << 27);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s4_ph_q[l]    <= s3_m_q[l] * TO_RAD_HI;
        s4_pl_q[l]    <= s3_m_q[l] * TO_RAD_LO;
        rot_z_q[0][l] <= cval_t'(rad_sum[60:28]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_neg_q     <= s3_neg_q;
      rot_neg_q[0] <= s4_neg_q;
    end
  end

  // ---------------------------------------------------------------------
  // Rotation CORDIC: one stage per step, four lanes side by side. Each
  // lane starts at (K, 0) and turns by its angle.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam cval_t ANG = cval_t'(atan_q32(i));

    for (genvar l = 0; l < 4; l++) begin : g_lane
      cval_t x_in;
      cval_t y_in;
      cval_t z_in;
      cval_t dx;
      cval_t dy;

      if (i == 0) begin : g_first
        assign x_in = K_C;
        assign y_in = '0;
      end else begin : g_next
        assign x_in = rot_x_q[i][l];
        assign y_in = rot_y_q[i][l];
      end

      assign z_in = rot_z_q[i][l];
      assign dx   = y_in >>> i;
      assign dy   = x_in >>> i;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (!z_in[CW-1]) begin
            rot_x_q[i+1][l] <= x_in - dx;
            rot_y_q[i+1][l] <= y_in + dy;
            rot_z_q[i+1][l] <= z_in - ANG;
          end else begin
            rot_x_q[i+1][l] <= x_in + dx;
            rot_y_q[i+1][l] <= y_in - dy;
            rot_z_q[i+1][l] <= z_in + ANG;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rot_neg_q[i+1] <= rot_neg_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Haversine term. Sines and cosines are clamped to the unit range and
  // handled as magnitude and sign, so every multiplier is 32 by 32 bits.
  // ---------------------------------------------------------------------
  logic [31:0] p1_s1m_q;
  logic [31:0] p1_s2m_q;
  logic [31:0] p1_c1m_q;
  logic [31:0] p1_c2m_q;
  logic        p1_cneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_s1m_q  <= unit_mag(rot_y_q[N][LANE_DLAT]);
      p1_s2m_q  <= unit_mag(rot_y_q[N][LANE_DLON]);
      p1_c1m_q  <= unit_mag(rot_x_q[N][LANE_LAT1]);
      p1_c2m_q  <= unit_mag(rot_x_q[N][LANE_LAT2]);
      p1_cneg_q <= rot_neg_q[N][0] ^ rot_x_q[N][LANE_LAT1][CW-1]
                 ^ rot_neg_q[N][1] ^ rot_x_q[N][LANE_LAT2][CW-1];
    end
  end

  logic [63:0] p2_t1_q;
  logic [63:0] p2_s2sq_q;
  logic [63:0] p2_cp_q;
  logic        p2_cneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_t1_q   <= p1_s1m_q * p1_s1m_q;
      p2_s2sq_q <= p1_s2m_q * p1_s2m_q;
      p2_cp_q   <= p1_c1m_q * p1_c2m_q;
      p2_cneg_q <= p1_cneg_q;
    end
  end

  // The cosine product is floored to Q31; for a negative product that
  // means rounding the magnitude up.
  logic [63:0] p3_cp_up;
  logic [31:0] p3_s2h_q;
  logic [31:0] p3_chm_q;
  logic [62:0] p3_t1_q;
  logic        p3_cneg_q;

  assign p3_cp_up = p2_cp_q + 64'h0000_0000_7FFF_FFFF;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_s2h_q  <= p2_s2sq_q[62:31];
      p3_chm_q  <= p2_cneg_q ? p3_cp_up[62:31] : p2_cp_q[62:31];
      p3_t1_q   <= p2_t1_q[62:0];
      p3_cneg_q <= p2_cneg_q;
    end
  end

  logic [63:0] p4_t3m_q;
  logic [62:0] p4_t1_q;
  logic        p4_cneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_t3m_q  <= p3_s2h_q * p3_chm_q;
      p4_t1_q   <= p3_t1_q;
      p4_cneg_q <= p3_cneg_q;
    end
  end

  logic signed [63:0] p5_t3_q;
  logic        [62:0] p5_t1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_t3_q <= p4_cneg_q ? -$signed({1'b0, p4_t3m_q[62:0]})
                           : $signed({1'b0, p4_t3m_q[62:0]});
      p5_t1_q <= p4_t1_q;
    end
  end

  // The sum saturates at one, and a negative sum (possible when a folded
  // latitude has a negative cosine) is taken as zero.
  logic signed [63:0] p6_lim;
  logic signed [63:0] p6_sum;
  logic        [62:0] p6_a_d;
  logic        [62:0] p6_a_q;

  always_comb begin
    p6_lim = $signed({1'b0, ONE_Q62}) - $signed({1'b0, p5_t1_q});
    p6_sum = $signed({1'b0, p5_t1_q}) + p5_t3_q;
    if (p5_t3_q > p6_lim) begin
      p6_a_d = ONE_Q62;
    end else if (p6_sum[63]) begin
      p6_a_d = '0;
    end else begin
      p6_a_d = p6_sum[62:0];
    end
  end

  logic [62:0] p7_a_q;
  logic [62:0] p7_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p6_a_q <= p6_a_d;
      p7_a_q <= p6_a_q;
      p7_b_q <= ONE_Q62 - p6_a_q;
    end
  end

  // ---------------------------------------------------------------------
  // Square roots of a and of 1 - a: restoring method, two radicand bits
  // per stage, both lanes side by side.
  // ---------------------------------------------------------------------
  logic [62:0] sq_v_q [1:SQRT_STEPS][2];
  logic [62:0] sq_r_q [1:SQRT_STEPS][2];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [62:0] v_in;
      logic [62:0] r_in;
      logic [63:0] trial;

      if (j == 0) begin : g_first
        assign v_in = (l == 0) ? p7_a_q : p7_b_q;
        assign r_in = '0;
      end else begin : g_next
        assign v_in = sq_v_q[j][l];
        assign r_in = sq_r_q[j][l];
      end

      assign trial = {1'b0, r_in} + SQ_BIT;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          if ({1'b0, v_in} >= trial) begin
            sq_v_q[j+1][l] <= 63'({1'b0, v_in} - trial);
            sq_r_q[j+1][l] <= 63'({1'b0, r_in >> 1} + SQ_BIT);
          end else begin
            sq_v_q[j+1][l] <= v_in;
            sq_r_q[j+1][l] <= r_in >> 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Vectoring CORDIC: drives (sqrt(1-a), sqrt(a)) onto the x axis and
  // accumulates the half central angle in Q32.
  // ---------------------------------------------------------------------
  cval_t vec_x_q [1:N];
  cval_t vec_y_q [1:N];
  cval_t vec_z_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam cval_t ANG = cval_t'(atan_q32(i));

    cval_t x_in;
    cval_t y_in;
    cval_t z_in;
    cval_t dx;
    cval_t dy;

    if (i == 0) begin : g_first
      assign x_in = cval_t'(sq_r_q[SQRT_STEPS][1][31:0]);
      assign y_in = cval_t'(sq_r_q[SQRT_STEPS][0][31:0]);
      assign z_in = '0;
    end else begin : g_next
      assign x_in = vec_x_q[i];
      assign y_in = vec_y_q[i];
      assign z_in = vec_z_q[i];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!y_in[CW-1]) begin
          vec_x_q[i+1] <= x_in + dx;
          vec_y_q[i+1] <= y_in - dy;
          vec_z_q[i+1] <= z_in + ANG;
        end else begin
          vec_x_q[i+1] <= x_in - dx;
          vec_y_q[i+1] <= y_in + dy;
          vec_z_q[i+1] <= z_in - ANG;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Scaling by the radius. The angle is clamped at zero and split into an
  // integer part and a 32-bit fraction; the result is rounded half up and
  // saturates at the output maximum.
  // ---------------------------------------------------------------------
  logic [CW-2:0] g1_zu;
  logic [33:0]   g1_mhi_q;
  logic [63:0]   g1_mlo_q;

  assign g1_zu = vec_z_q[N][CW-1] ? '0 : vec_z_q[N][CW-2:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_mhi_q <= radius_q * g1_zu[CW-2:32];
      g1_mlo_q <= radius_q * g1_zu[31:0];
    end
  end

  logic [63:0] g2_lo_rnd;
  logic [35:0] g2_sum;
  logic [31:0] dist_d;
  logic [31:0] dist_q;

  always_comb begin
    g2_lo_rnd = g1_mlo_q + (64'd1 << 30);
    g2_sum    = {1'b0, g1_mhi_q, 1'b0} + {3'b000, g2_lo_rnd[63:31]};
    dist_d    = (|g2_sum[35:32]) ? 32'hFFFF_FFFF : g2_sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
    end
  end

  assign distance_o = dist_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_hav_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_P6] |-> (p6_a_q <= ONE_Q62))
    else $error("haversine term above one");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_SQ] |-> ((sq_r_q[SQRT_STEPS][0] <= (63'd1 << 31))
                  && (sq_r_q[SQRT_STEPS][1] <= (63'd1 << 31))))
    else $error("square root above one");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");

endmodule

/* tb/haversine_distance_core_tb.sv */
// Self-checking testbench for the haversine distance core: directed table, then random
// coordinate pairs checked against a bit-exact fixed-point predictor held here.
// Depends on hav_dist_pkg and haversine_distance_core.
`timescale 1ns / 100ps

module haversine_distance_core_tb
  import hav_dist_pkg::*;
;

  localparam int STEPS = 24;
  localparam int PIPE_DEPTH = 46 + 2 * STEPS;
  localparam longint HALF_TURN_U = 64'sd1800000000;
  localparam longint TURN_U = 64'sd3600000000;
  localparam longint QUARTER_U = 64'sd900000000;
  localparam longint UNIT_Q31 = 64'sd1 << 31;
  localparam longint UNIT_Q62 = 64'sd1 << 62;
  localparam longint unsigned PI_Q60_C = 64'h3243_F6A8_885A_308D;

  typedef struct {
    logic signed [30:0] lat1;
    logic signed [31:0] lon1;
    logic signed [30:0] lat2;
    logic signed [31:0] lon2;
  } coord_pair_t;

  typedef struct {
    logic [31:0] radius;
    coord_pair_t pair;
    bit          known;
    logic [31:0] want_dist;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [30:0] start_lat, end_lat;
  logic signed [31:0] start_lon, end_lon;
  logic [31:0] distance, radius_wr;

  haversine_distance_core #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_lat_i(start_lat), .start_lon_i(start_lon),
    .end_lat_i(end_lat), .end_lon_i(end_lon),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .distance_o(distance),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .earth_radius_i(radius_wr)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the radius it believes the core holds, and the constant tables.
  logic [31:0]  radius_now;
  longint       atan_tab [32];
  longint       cordic_k;
  logic [31:0]  dist_queue [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           results_seen = 0;
  int           radius_writes = 0;
  int           hold_reqs = 0;
  int           holds_done = 0;

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void build_tables();
    longint acc;
    longint unsigned g;
    int e;
    for (int i = 0; i < 32; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = longint'(PI_Q60_C);
      end else begin
        for (int k = 0; ; k++) begin
          e = 62 - i * (2 * k + 1);
          if (e < 0) break;
          if (k % 2 == 1) acc -= longint'((64'd1 << e) / (2 * k + 1));
          else acc += longint'((64'd1 << e) / (2 * k + 1));
        end
      end
      atan_tab[i] = (acc + (64'sd1 << 29)) >>> 30;
    end
    g = 64'd1 << 60;
    for (int i = 0; i < STEPS && i < 32; i++) g += g >> (2 * i);
    cordic_k = longint'((64'd1 << 61) / sqrt_floor(g));
  endfunction

  // Angle in units of 1e-7 degree to half-angle radians in Q32.
  function automatic longint rad_of(longint unsigned m);
    longint unsigned q, r, c, t;
    q = PI_Q60_C / 64'd3600000000;
    r = PI_Q60_C % 64'd3600000000;
    c = (q << 32) + ((r << 32) / 64'd3600000000);
    t = m * (c >> 32) + ((m * (c & 64'hFFFF_FFFF)) >> 32);
    return longint'((t + (64'd1 << 27)) >> 28);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT_Q31) return UNIT_Q31;
    if (v < -UNIT_Q31) return -UNIT_Q31;
    return v;
  endfunction

  function automatic void spin(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = cordic_k;
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endfunction

  function automatic longint arc_of(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint turn_wrap(longint d);
    longint r;
    r = d % TURN_U;
    if (r >= HALF_TURN_U) r -= TURN_U;
    if (r < -HALF_TURN_U) r += TURN_U;
    return r;
  endfunction

  function automatic longint sin_of_half(longint d);
    longint r, c, s;
    r = turn_wrap(d);
    spin(rad_of(longint'(r < 0 ? -r : r)), c, s);
    return s;
  endfunction

  function automatic longint cos_of_lat(longint lat);
    longint m, c, s;
    bit flip;
    m = turn_wrap(lat);
    if (m < 0) m = -m;
    flip = m > QUARTER_U;
    if (flip) m = HALF_TURN_U - m;
    spin(rad_of(2 * m), c, s);
    return flip ? -c : c;
  endfunction

  function automatic logic [31:0] great_circle_distance(coord_pair_t p, logic [31:0] rad);
    longint s1, s2, c1, c2, t1, t3, hav, z;
    longint unsigned sa, sb, zu, r, dist_raw;
    s1 = sin_of_half(longint'(p.lat2) - longint'(p.lat1));
    s2 = sin_of_half(longint'(p.lon2) - longint'(p.lon1));
    c1 = cos_of_lat(longint'(p.lat1));
    c2 = cos_of_lat(longint'(p.lat2));
    t1 = s1 * s1;
    t3 = ((s2 * s2) >>> 31) * ((c1 * c2) >>> 31);
    if (t3 > UNIT_Q62 - t1) hav = UNIT_Q62;
    else hav = t1 + t3;
    if (hav < 0) hav = 0;
    sa = sqrt_floor(longint'(hav));
    sb = sqrt_floor(longint'(UNIT_Q62 - hav));
    z = arc_of(longint'(sb), longint'(sa));
    zu = z < 0 ? 0 : longint'(z);
    r = {32'd0, rad};
    dist_raw = ((r * (zu >> 32)) << 1) + ((r * (zu & 64'hFFFF_FFFF) + (64'd1 << 30)) >> 31);
    if (dist_raw > 64'hFFFF_FFFF) dist_raw = 64'hFFFF_FFFF;
    return dist_raw[31:0];
  endfunction

  // Result side: the receiver stalls on a pattern that steps through four modes, and
  // honours a request for one long hold-off counted here.
  int unsigned cyc = 0;
  int          hold_left = 0;
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
      if (hold_left == 1) holds_done <= holds_done + 1;
    end else if (hold_reqs > holds_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else begin
      case ((cyc / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(7) == 0);
        2: out_stall <= ($urandom_range(1) == 0);
        default: out_stall <= (cyc % 3 == 0);
      endcase
    end
  end

  // Each accepted result is checked against the oldest expected distance.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (dist_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: distance %0d", distance);
      end else begin
        logic [31:0] want;
        want = dist_queue.pop_front();
        if (distance !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d, got %0d", want, distance);
        end
      end
    end
  end

  // Sender bursts: items left in the current burst, and whether gaps are allowed.
  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  task automatic offer(coord_pair_t p, bit known, logic [31:0] want_dist);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(6) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid = 1'b1;
    start_lat = p.lat1;
    start_lon = p.lon1;
    end_lat = p.lat2;
    end_lon = p.lon2;
    do @(posedge clk); while (in_stall);
    dist_queue.push_back(known ? want_dist : great_circle_distance(p, radius_now));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (dist_queue.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic set_radius(logic [31:0] v);
    drain();
    cfg_valid = 1'b1;
    radius_wr = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    radius_now = v;
    radius_writes++;
  endtask

  function automatic logic signed [31:0] lat_in_range();
    return 32'(longint'($urandom_range(1800000000)) - 900000000);
  endfunction

  function automatic logic signed [31:0] lon_in_range();
    return 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
  endfunction

  // Random pairs: mostly real positions, with near pairs, near-antipodal pairs,
  // raw bit patterns and extremes mixed in.
  function automatic coord_pair_t random_pair();
    coord_pair_t p;
    logic [31:0] ext [4];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    p.lat1 = 31'(lat_in_range());
    p.lon1 = lon_in_range();
    p.lat2 = 31'(lat_in_range());
    p.lon2 = lon_in_range();
    case ($urandom_range(9))
      4: begin
        p.lat1 = 31'($urandom());
        p.lon1 = $urandom();
        p.lat2 = 31'($urandom());
        p.lon2 = $urandom();
      end
      5: begin
        p.lat2 = p.lat1 + 31'(int'($urandom_range(2000)) - 1000);
        p.lon2 = p.lon1 + (int'($urandom_range(2000)) - 1000);
      end
      6: begin
        p.lat2 = -p.lat1 + 31'(int'($urandom_range(2000)) - 1000);
        p.lon2 = p.lon1 + 32'sd1800000000 + (int'($urandom_range(2000)) - 1000);
      end
      7: begin
        p.lat1 = 31'(ext[$urandom_range(3)]);
        p.lon1 = ext[$urandom_range(3)];
        p.lat2 = 31'(ext[$urandom_range(3)]);
        p.lon2 = ext[$urandom_range(3)];
      end
      default: ;
    endcase
    return p;
  endfunction

  // Directed rows: the reset radius first, then zero and full-scale radii, mostly where
  // the distance can be told without working it out.
  dir_row_t dir_rows [] = '{
    '{RADIUS_RESET, '{31'sd0, 32'sd0, 31'sd0, 32'sd0}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 31'sh4000_0000, 32'sh8000_0000},
      1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sh4000_0000, 32'sd0, 31'sh3FFF_FFFF, 32'sd0}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd1000000000, 32'sd100, 31'sd1000000000, -32'sd100}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd950000000, 32'sd0, 31'sd850000000, 32'sd1800000000},
      1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd0, -32'sd1790000000, 31'sd0, 32'sd1790000000}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd0, 32'sd1, 31'sd0, 32'sd0}, 1'b0, 32'd0},
    '{RADIUS_RESET, '{31'sd450000000, 32'sd123, -31'sd450000000, 32'sd1800000123},
      1'b0, 32'd0},
    '{RADIUS_RESET, '{-31'sd899999999, -32'sd1800000000, 31'sd899999999, 32'sd1800000000},
      1'b0, 32'd0},
    '{32'd0, '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000}, 1'b1, 32'd0},
    '{32'd0, '{31'sd123, 32'sd456, -31'sd789, 32'sd1000}, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000}, 1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0}, 1'b1,
      32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, '{31'sd0, 32'sd0, 31'sd0, 32'sd0}, 1'b0, 32'd0}
  };

  initial begin
    logic [31:0] phase_radius [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    radius_wr = '0;
    start_lat = '0;
    start_lon = '0;
    end_lat = '0;
    end_lon = '0;
    out_stall = 1'b0;
    radius_now = RADIUS_RESET;
    build_tables();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The reset radius is only changed once the rows that rely on it are through.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].radius !== radius_now) set_radius(dir_rows[i].radius);
      offer(dir_rows[i].pair, dir_rows[i].known, dir_rows[i].want_dist);
    end

    phase_radius = '{RADIUS_RESET, 32'hFFFF_FFFF, $urandom(), 32'd0, 32'd417542963,
                     32'd1};
    for (int ph = 0; ph < 6; ph++) begin
      set_radius(phase_radius[ph]);
      gaps_on = (ph != 4);
      for (int n = 0; n < 305; n++) begin
        // Phase one: a long receiver hold-off so that the pipeline fills and
        // pushes back; phase two: the sender waits for every result mid-phase.
        if (ph == 1 && n == 50) hold_reqs++;
        if (ph == 2 && n == 150) begin
          in_valid = 1'b0;
          while (dist_queue.size() != 0) @(negedge clk);
        end
        offer(random_pair(), 1'b0, 32'd0);
      end
    end

    drain();
    $display("Checked %0d results from %0d items over %0d radius settings,",
             results_seen, items_sent, radius_writes);
    $display("with back-pressure, idle gaps, wrapped angles and saturated distances.");
    if (mismatches == 0 && dist_queue.size() == 0) begin
      $display("haversine_distance_core_tb: done, clean");
    end else begin
      $display("haversine_distance_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d results still due.", dist_queue.size());
    $display("haversine_distance_core_tb: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/hav_dist_pkg.sv
rtl/core/haversine_distance_core.sv
tb/haversine_distance_core_tb.sv
